[rtl/core/htsp_pkg.sv]
// Package for the HTML tag stripper: result types, character constants and
// the opener / end-marker lookup functions. No dependencies.
package htsp_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [1:0] IdxScript  = 2'd0;
  localparam logic [1:0] IdxStyle   = 2'd1;
  localparam logic [1:0] IdxComment = 2'd2;

  localparam logic [AddrW-1:0] RegSeparate = 3'd0;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       doc_done;
    logic       run_last;
  } htsp_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    htsp_res_t  res0;
    htsp_res_t  res1;
  } htsp_pair_t;

  function automatic logic [2:0] open_len(input logic [1:0] idx);
    case (idx)
      IdxScript: open_len = 3'd6;
      IdxStyle:  open_len = 3'd5;
      default:   open_len = 3'd3;
    endcase
  endfunction

  function automatic logic [3:0] close_len(input logic [1:0] idx);
    case (idx)
      IdxScript: close_len = 4'd8;
      IdxStyle:  close_len = 4'd7;
      default:   close_len = 4'd3;
    endcase
  endfunction

  // "script", "style", "!--"
  function automatic logic [7:0] open_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CharNul;
    case (idx)
      IdxScript: begin
        case (pos)
          3'd0: ch = 8'h73;
          3'd1: ch = 8'h63;
          3'd2: ch = 8'h72;
          3'd3: ch = 8'h69;
          3'd4: ch = 8'h70;
          3'd5: ch = 8'h74;
          default: ch = CharNul;
        endcase
      end
      IdxStyle: begin
        case (pos)
          3'd0: ch = 8'h73;
          3'd1: ch = 8'h74;
          3'd2: ch = 8'h79;
          3'd3: ch = 8'h6C;
          3'd4: ch = 8'h65;
          default: ch = CharNul;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = 8'h21;
          3'd1: ch = CharDash;
          3'd2: ch = CharDash;
          default: ch = CharNul;
        endcase
      end
    endcase
    return ch;
  endfunction

  // "/script>", "/style>", "-->"
  function automatic logic [7:0] close_char(input logic [1:0] idx, input logic [3:0] pos);
    logic [7:0] ch;
    ch = CharNul;
    case (idx)
      IdxScript: begin
        case (pos)
          4'd0: ch = CharSlash;
          4'd1: ch = 8'h73;
          4'd2: ch = 8'h63;
          4'd3: ch = 8'h72;
          4'd4: ch = 8'h69;
          4'd5: ch = 8'h70;
          4'd6: ch = 8'h74;
          4'd7: ch = CharGt;
          default: ch = CharNul;
        endcase
      end
      IdxStyle: begin
        case (pos)
          4'd0: ch = CharSlash;
          4'd1: ch = 8'h73;
          4'd2: ch = 8'h74;
          4'd3: ch = 8'h79;
          4'd4: ch = 8'h6C;
          4'd5: ch = 8'h65;
          4'd6: ch = CharGt;
          default: ch = CharNul;
        endcase
      end
      default: begin
        case (pos)
          4'd0: ch = CharDash;
          4'd1: ch = CharDash;
          4'd2: ch = CharGt;
          default: ch = CharNul;
        endcase
      end
    endcase
    return ch;
  endfunction

  // lowest set candidate wins
  function automatic logic [1:0] cand_index(input logic [2:0] cand);
    if (cand[0]) return IdxScript;
    if (cand[1]) return IdxStyle;
    return IdxComment;
  endfunction

endpackage

[rtl/core/htsp_in_if.sv]
// Input request channel of the HTML tag stripper: valid/ready plus one byte.
// No dependencies.
interface htsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       doc_last;

  modport source (output valid, output in_byte, output doc_last, input ready);
  modport sink   (input valid, input in_byte, input doc_last, output ready);
endinterface

[rtl/core/htsp_out_if.sv]
// Result request channel of the HTML tag stripper: valid/ready plus one
// result item. No dependencies.
interface htsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       doc_done;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output doc_done,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input doc_done,
                  input run_last, output ready);
endinterface

[rtl/core/htsp_parser.sv]
// Markup parser state machine: classifies one byte per advance and forms its
// zero, one or two result items. Depends on htsp_pkg.
module htsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          cur_byte,
  input  logic                cur_last,
  input  logic                separate_mode,
  output htsp_pkg::htsp_pair_t pair
);
  import htsp_pkg::*;

  typedef enum logic [2:0] {
    ModeText  = 3'd0,
    ModeOpen  = 3'd1,
    ModeTag   = 3'd2,
    ModeSkip  = 3'd3,
    ModeDrain = 3'd4
  } mode_t;

  mode_t      mode_r,   mode_nxt;
  logic [2:0] opos_r,   opos_nxt;
  logic [2:0] cand_r,   cand_nxt;
  logic [3:0] cpos_r,   cpos_nxt;
  logic       in_run_r, in_run_nxt;

  logic [2:0] keep;
  logic [1:0] kidx;
  logic [1:0] sidx;
  logic [3:0] p;
  logic [3:0] p_inc;

  always_comb begin
    mode_nxt   = mode_r;
    opos_nxt   = opos_r;
    cand_nxt   = cand_r;
    cpos_nxt   = cpos_r;
    in_run_nxt = in_run_r;
    pair       = '0;
    keep       = '0;
    kidx       = cand_index(3'd0);
    sidx       = cand_index(cand_r);
    p          = cpos_r;
    p_inc      = '0;

    unique case (mode_r)
      ModeOpen: begin
        if (cur_byte == CharNul) begin
          mode_nxt = ModeDrain;
        end else if (cur_byte == CharGt) begin
          mode_nxt = ModeText;
        end else begin
          for (int i = 0; i < 3; i++) begin
            keep[i] = cand_r[i] && (opos_r < open_len(2'(i))) &&
                      (open_char(2'(i), opos_r) == cur_byte);
          end
          cand_nxt = keep;
          kidx     = cand_index(keep);
          if (keep == 3'd0) begin
            mode_nxt = ModeTag;
          end else if (3'(opos_r + 3'd1) == open_len(kidx)) begin
            mode_nxt = ModeSkip;
            cand_nxt = 3'(3'd1 << kidx);
            cpos_nxt = (kidx == IdxComment) ? 4'd2 : 4'd0;
          end else begin
            opos_nxt = 3'(opos_r + 3'd1);
          end
        end
      end
      ModeTag: begin
        if (cur_byte == CharNul) begin
          mode_nxt = ModeDrain;
        end else if (cur_byte == CharGt) begin
          mode_nxt = ModeText;
        end
      end
      ModeSkip: begin
        if (cur_byte == CharNul) begin
          mode_nxt = ModeDrain;
        end else begin
          if (p >= close_len(sidx)) p = 4'd0;
          p_inc = 4'(p + 4'd1);
          if (close_char(sidx, p) == cur_byte) begin
            if (p_inc == close_len(sidx)) begin
              mode_nxt = ModeText;
              cpos_nxt = 4'd0;
            end else begin
              cpos_nxt = p_inc;
            end
          end else if (sidx == IdxComment && p == 4'd2 && cur_byte == CharDash) begin
            cpos_nxt = 4'd2;
          end else begin
            cpos_nxt = (close_char(sidx, 4'd0) == cur_byte) ? 4'd1 : 4'd0;
          end
        end
      end
      ModeDrain: begin
      end
      default: begin
        if (cur_byte == CharNul) begin
          mode_nxt   = ModeDrain;
          in_run_nxt = 1'b0;
        end else if (cur_byte == CharLt) begin
          mode_nxt   = ModeOpen;
          opos_nxt   = 3'd0;
          cand_nxt   = 3'b111;
          in_run_nxt = 1'b0;
        end else begin
          mode_nxt   = ModeText;
          in_run_nxt = 1'b1;
          if (separate_mode && !in_run_r) begin
            pair.cnt             = 2'd2;
            pair.res0.out_byte   = CharSlash;
            pair.res0.byte_valid = 1'b1;
            pair.res1.out_byte   = cur_byte;
            pair.res1.byte_valid = 1'b1;
            pair.res1.run_last   = 1'b1;
          end else begin
            pair.cnt             = 2'd1;
            pair.res0.out_byte   = cur_byte;
            pair.res0.byte_valid = 1'b1;
            pair.res0.run_last   = 1'b1;
          end
        end
      end
    endcase

    if (cur_last) begin
      if (pair.cnt == 2'd0) begin
        pair.cnt           = 2'd1;
        pair.res0.run_last = 1'b1;
      end
      pair.res0.doc_done = 1'b1;
      pair.res1.doc_done = 1'b1;
      mode_nxt   = ModeText;
      opos_nxt   = 3'd0;
      cand_nxt   = 3'b111;
      cpos_nxt   = 4'd0;
      in_run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ModeText;
      opos_r   <= 3'd0;
      cand_r   <= 3'b111;
      cpos_r   <= 4'd0;
      in_run_r <= 1'b0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      opos_r   <= opos_nxt;
      cand_r   <= cand_nxt;
      cpos_r   <= cpos_nxt;
      in_run_r <= in_run_nxt;
    end
  end

endmodule

[rtl/core/htsp_out_fifo.sv]
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on htsp_pkg.
module htsp_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    push_cnt,
  input  htsp_pkg::htsp_res_t           push0,
  input  htsp_pkg::htsp_res_t           push1,
  input  logic                          pop,
  output htsp_pkg::htsp_res_t           head,
  output logic [htsp_pkg::CntW-1:0]     count
);
  import htsp_pkg::*;

  htsp_res_t       mem_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;
  logic [PtrW-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = PtrW'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = PtrW'(wr_ptr_r + push_cnt);
  assign rd_ptr_nxt = PtrW'(rd_ptr_r + pop);
  assign count_nxt  = CntW'(count_r + CntW'(push_cnt) - CntW'(pop));
  assign head       = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/html_tag_stripper.sv]
// HTML tag stripper top level: input register, parser, result queue, APB register.
// Depends on htsp_pkg, htsp_in_if, htsp_out_if, htsp_parser, htsp_out_fifo.
//
// Takes one document byte per cycle while the input is not stalled and returns
// the text outside markup; script, style and comment blocks are dropped up to
// their end markers. Each accepted byte is registered, parsed combinationally
// and its results (zero, one or two) written into a four-entry result queue,
// so bytes stream at one per cycle while each causes at most one result and
// the receiver keeps up. A byte that opens a text run in separate mode causes
// two results (slash and byte); the queue absorbs the extra one. The input stalls
// only when the queue lacks room for the registered byte's results. Register 0 at
// byte address 0 holds separate_mode; write it only while the block is idle.
module html_tag_stripper (
  input  logic                          clk,
  input  logic                          rst_n,
  htsp_in_if.sink                       in_ch,
  htsp_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htsp_pkg::AddrW-1:0]    paddr,
  input  logic [htsp_pkg::DataW-1:0]    pwdata,
  output logic [htsp_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import htsp_pkg::*;

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  logic            sep_r;
  logic            s1_fire;
  logic            in_take;
  logic            pop;
  logic            reg_hit;
  logic [CntW-1:0] q_count;
  logic [CntW-1:0] q_free;
  htsp_pair_t      pair;
  htsp_res_t       head;

  assign reg_hit = (paddr[AddrW-1:2] == RegSeparate[AddrW-1:2]);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(DataW-1){1'b0}}, sep_r} : '0;

  assign q_free       = CntW'(FifoDepth) - q_count;
  assign s1_fire      = s1_valid_r && (CntW'(pair.cnt) <= q_free);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_take      = in_ch.valid && in_ch.ready;

  htsp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (s1_fire),
    .cur_byte      (s1_byte_r),
    .cur_last      (s1_last_r),
    .separate_mode (sep_r),
    .pair          (pair)
  );

  htsp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (s1_fire ? pair.cnt : 2'd0),
    .push0    (pair.res0),
    .push1    (pair.res1),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  assign out_ch.valid      = (q_count != '0);
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.byte_valid = head.byte_valid;
  assign out_ch.doc_done   = head.doc_done;
  assign out_ch.run_last   = head.run_last;
  assign pop               = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sep_r      <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && reg_hit) begin
        sep_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.doc_last;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> (pair.cnt != 2'd0))
    else $error("final byte produced no result");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pair.cnt == 2'd2) |-> (!pair.res0.run_last && pair.res1.run_last &&
                                       pair.res0.out_byte == CharSlash))
    else $error("two-result item misordered");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && reg_hit) |=> (sep_r == $past(pwdata[0])))
    else $error("separate_mode write lost");

endmodule

[tb/sv/tb_html_tag_stripper.sv]
`timescale 1ns / 1ps
// Self-checking testbench for html_tag_stripper: document bytes in, kept text out.
// Needs htsp_pkg, htsp_in_if, htsp_out_if and the html_tag_stripper RTL.
module tb_html_tag_stripper;
  import htsp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldAt      = 120;
  localparam int unsigned HoldCycles  = 90;
  localparam logic [AddrW-1:0] SepAddr = AddrW'(4 * RegSeparate);

  class strip_scoreboard;
    typedef enum logic [2:0] {PmText, PmOpen, PmTag, PmSkip, PmDrain} parse_mode_t;

    string openers[3] = '{"script", "style", "!--"};
    string closers[3] = '{"/script>", "/style>", "-->"};
    bit          separate;
    parse_mode_t mode;
    int          opos;
    int          cpos;
    logic [2:0]  cand;
    bit          in_run;
    htsp_res_t   kept_text[$];
    int          errors;

    function new();
      separate = 1'b0;
      errors   = 0;
      restart_doc();
    endfunction

    function void restart_doc();
      mode   = PmText;
      opos   = 0;
      cand   = 3'b111;
      cpos   = 0;
      in_run = 1'b0;
    endfunction

    function void set_separate(bit v);
      separate = v;
    endfunction

    function int pending();
      return kept_text.size();
    endfunction

    function int first_cand(logic [2:0] m);
      if (m[0]) return 0;
      if (m[1]) return 1;
      return 2;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void strip_byte(logic [7:0] b, logic last);
      logic [7:0] txt[$];
      logic [2:0] keep;
      int         c;
      int         p;
      htsp_res_t  r;
      case (mode)
        PmOpen: begin
          if (b == CharNul) begin
            mode = PmDrain;
          end else if (b == CharGt) begin
            mode = PmText;
          end else begin
            keep = 3'b000;
            for (int i = 0; i < 3; i++)
              if (cand[i] && opos < openers[i].len() &&
                  logic'(8'(openers[i][opos]) == b))
                keep[i] = 1'b1;
            cand = keep;
            if (keep == 3'b000) begin
              mode = PmTag;
            end else begin
              c = first_cand(keep);
              if (opos + 1 == openers[c].len()) begin
                mode = PmSkip;
                cand = 3'b001 << c;
                cpos = (c == 2) ? 2 : 0;
              end else begin
                opos = (opos + 1) & 7;
              end
            end
          end
        end
        PmTag: begin
          if (b == CharNul) mode = PmDrain;
          else if (b == CharGt) mode = PmText;
        end
        PmSkip: begin
          if (b == CharNul) begin
            mode = PmDrain;
          end else begin
            c = first_cand(cand);
            p = cpos;
            if (p >= closers[c].len()) p = 0;
            if (8'(closers[c][p]) == b) begin
              p++;
              if (p == closers[c].len()) begin
                mode = PmText;
                p = 0;
              end
            end else if (c == 2 && p == 2 && b == CharDash) begin
              p = 2;
            end else begin
              p = (8'(closers[c][0]) == b) ? 1 : 0;
            end
            cpos = p & 15;
          end
        end
        PmDrain: ;
        default: begin
          if (b == CharNul) begin
            mode   = PmDrain;
            in_run = 1'b0;
          end else if (b == CharLt) begin
            mode   = PmOpen;
            opos   = 0;
            cand   = 3'b111;
            in_run = 1'b0;
          end else begin
            mode = PmText;
            if (separate && !in_run) txt.push_back(CharSlash);
            txt.push_back(b);
            in_run = 1'b1;
          end
        end
      endcase

      if (last && txt.size() == 0) begin
        r = '{out_byte: CharNul, byte_valid: 1'b0, doc_done: 1'b1, run_last: 1'b1};
        kept_text.push_back(r);
      end
      for (int k = 0; k < txt.size(); k++) begin
        r = '{out_byte: txt[k], byte_valid: 1'b1, doc_done: last,
              run_last: (k == txt.size() - 1)};
        kept_text.push_back(r);
      end
      if (last) restart_doc();
    endfunction

    task compare_kept(htsp_res_t got);
      htsp_res_t want;
      if (kept_text.size() == 0) begin
        report($sformatf("unexpected result, out_byte %h", got.out_byte));
        return;
      end
      want = kept_text.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.doc_done !== want.doc_done)
        report($sformatf("doc_done %b, want %b", got.doc_done, want.doc_done));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  htsp_in_if  in_ch();
  htsp_out_if out_ch();

  html_tag_stripper i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  strip_scoreboard sb = new();
  int unsigned     req_count = 0;
  int unsigned     cycle_count = 0;
  logic [7:0]      doc_bytes[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  function automatic bit calm_window();
    return req_count >= 300 && req_count < 400;
  endfunction

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && req_count >= HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm_window() || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.compare_kept(htsp_res_t'{out_ch.out_byte, out_ch.byte_valid,
                                  out_ch.doc_done, out_ch.run_last});
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm_window() && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.doc_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    req_count++;
    sb.strip_byte(b, last);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++)
      send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic reg_write_verify(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_separate(d[0]);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== d)
      sb.report($sformatf("register read %h, want %h", prdata, d));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(8'(s[i]));
  endfunction

  function automatic void put_text(int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(99) < 2) ? CharNul : 8'($urandom_range(255, 1));
      if (v == CharLt) v = 8'h74;
      doc_bytes.push_back(v);
    end
  endfunction

  function automatic void put_tag_body(int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom_range(255, 1));
      if (v == CharGt) v = 8'h61;
      doc_bytes.push_back(v);
    end
  endfunction

  // block content biased toward partial end markers
  function automatic void put_junk(int n);
    string alpha;
    alpha = "scriptyle/-->!<a";
    for (int i = 0; i < n; i++)
      doc_bytes.push_back(8'(alpha[$urandom_range(alpha.len() - 1)]));
  endfunction

  function automatic void make_doc();
    string names[3] = '{"script", "style", "!--"};
    string op;
    int    segs;
    doc_bytes.delete();
    segs = $urandom_range(5, 1);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(9))
        0, 1, 2: put_text($urandom_range(8, 1));
        3: begin
          put_str("<");
          put_tag_body($urandom_range(4));
          put_str(">");
        end
        4: begin
          put_str("<script");
          put_junk($urandom_range(10));
          put_str("/script>");
        end
        5: begin
          put_str("<style");
          put_junk($urandom_range(10));
          put_str("/style>");
        end
        6: begin
          put_str("<!--");
          put_junk($urandom_range(10));
          put_str("-->");
        end
        7: begin
          op = names[$urandom_range(2)];
          put_str("<");
          put_str(op.substr(0, $urandom_range(op.len() - 2)));
          if ($urandom_range(1)) doc_bytes.push_back(8'($urandom_range(8'h7a, 8'h61)));
          if ($urandom_range(3) != 0) put_str(">");
        end
        8: begin
          for (int i = $urandom_range(4, 1); i > 0; i--)
            doc_bytes.push_back(8'($urandom_range(255)));
        end
        default: begin
          // tag or block left open to the end of the document
          case ($urandom_range(2))
            0: begin
              put_str("<");
              put_tag_body($urandom_range(4));
            end
            1: begin
              put_str("<script");
              put_junk($urandom_range(6));
            end
            default: begin
              put_str("<!--");
              put_junk($urandom_range(6));
            end
          endcase
          break;
        end
      endcase
    end
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned start;
    start = req_count;
    while (req_count - start < n) begin
      make_doc();
      send_doc();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.doc_last <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_write_verify(SepAddr, 32'd0);
    put_str("A<!-->B");
    send_doc();
    put_str("<s>");
    doc_bytes.push_back(8'hFF);
    send_doc();
    put_str("<b");
    send_doc();
    put_str("q");
    doc_bytes.push_back(CharNul);
    put_str("z");
    send_doc();
    put_str("x<p>y");
    send_doc();
    random_phase(220);
    settle();

    reg_write_verify(SepAddr, 32'd1);
    random_phase(220);
    settle();

    reg_write_verify(SepAddr, 32'd0);
    random_phase(60);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/htsp_pkg.sv
rtl/core/htsp_in_if.sv
rtl/core/htsp_out_if.sv
rtl/core/htsp_parser.sv
rtl/core/htsp_out_fifo.sv
rtl/core/html_tag_stripper.sv
tb/sv/tb_html_tag_stripper.sv
